// ===== rtl/ufpd_pkg.sv =====
package ufpd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // most result items one input item can cause
    localparam int BUNDLE_MAX = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } t_out_item;

    // decoded bytes of one input item, oldest in entry 0
    typedef struct packed {
        logic [BUNDLE_MAX-1:0][7:0] bytes;
        logic [1:0]                 cnt;
        logic                       last;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            // 'A'..'F' and 'a'..'f' share the low bits 1..6
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/url_form_percent_decoder_unit.sv =====
// Percent decoder for form-encoded fields.
// Input channel: one raw byte per item with in_end on the field's last byte;
// the item is taken on an edge with push high and full low.
// Result channel: a queue view; while empty is low the oldest decoded byte
// sits on o_out, and pop with empty low takes it. out_end marks the final
// decoded byte of a field.
// '+' becomes a space, %XX becomes one byte, a broken escape comes out as
// the literal bytes. An item yields 0 to 3 result items.
// An item's first result goes through the bundle queue register to o_out.
// Input items are taken one per cycle while full is low; results leave one
// per cycle while pop is held, so the sustained rate is set by the result
// count; the bundle queue between classifier and expander absorbs bursts.
// Stalling pop holds the current result; the queue fills and full rises.
// Reset (synchronous, i_rst_n low) clears the held escape and empties the
// queue; nothing is delivered from before reset.
module url_form_percent_decoder_unit
    import ufpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out
);

    logic    w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_bundle w_bundle, w_head;

    assign full = w_q_full;

    ufpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_bundle (w_bundle)
    );

    ufpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_bundle),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    ufpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_head    (w_head),
        .o_q_pop   (w_q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/ufpd_front.sv =====
module ufpd_front
    import ufpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_bundle  o_bundle
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_bundle    w_b;
    logic       w_accept;

    assign w_accept = i_push && !i_q_full;

    always_comb begin
        logic [7:0] b;
        logic [7:0] p;
        b = i_in.in_byte;
        p = (b == PLUS_CHAR) ? SPACE_CHAR : b;
        w_b = '0;
        n_phase = r_phase;
        n_held = r_held;

        unique case (r_phase)
            PH_PCT: begin
                if (is_hex(b)) begin
                    n_held = b;
                    n_phase = PH_DIGIT;
                end else begin
                    w_b.bytes[0] = PCT_CHAR;
                    w_b.cnt = 2'd1;
                    if (b == PCT_CHAR) begin
                        n_phase = PH_PCT;
                    end else begin
                        w_b.bytes[1] = p;
                        w_b.cnt = 2'd2;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                n_held = '0;
                if (is_hex(b)) begin
                    w_b.bytes[0] = {hex_nib(r_held), hex_nib(b)};
                    w_b.cnt = 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    w_b.bytes[0] = PCT_CHAR;
                    w_b.bytes[1] = r_held;
                    w_b.cnt = 2'd2;
                    if (b == PCT_CHAR) begin
                        n_phase = PH_PCT;
                    end else begin
                        w_b.bytes[2] = p;
                        w_b.cnt = 2'd3;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                if (b == PCT_CHAR) begin
                    n_phase = PH_PCT;
                end else begin
                    w_b.bytes[0] = p;
                    w_b.cnt = 2'd1;
                    n_phase = PH_IDLE;
                end
            end
        endcase

        // field end: flush whatever is still held
        if (i_in.in_end) begin
            if (n_phase == PH_PCT) begin
                if (w_b.cnt != 2'd3) begin
                    w_b.bytes[w_b.cnt] = PCT_CHAR;
                end
                w_b.cnt = w_b.cnt + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                // only reachable from a held percent sign with nothing emitted
                w_b.bytes[0] = PCT_CHAR;
                w_b.bytes[1] = n_held;
                w_b.cnt = 2'd2;
            end
            w_b.last = 1'b1;
            n_phase = PH_IDLE;
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_q_push = w_accept && (w_b.cnt != 2'd0);
    assign o_bundle = w_b;

endmodule

// ===== rtl/ufpd_queue.sv =====
module ufpd_queue
    import ufpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle        r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/ufpd_back.sv =====
module ufpd_back
    import ufpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_bundle   i_head,
    output logic      o_q_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out
);

    logic [1:0] r_idx;
    logic       w_last;

    // final byte of the head bundle is on the port
    assign w_last = (r_idx == i_head.cnt - 2'd1);

    assign empty          = i_q_empty;
    assign o_out.out_byte = (r_idx == 2'd3) ? 8'h00 : i_head.bytes[r_idx];
    assign o_out.out_end  = i_head.last && w_last;
    assign o_q_pop        = pop && !i_q_empty && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (pop && !i_q_empty) begin
            r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule
